/* rtl/rrts_pkg.sv */
package rrts_pkg;

    localparam logic [2:0] ST_READY      = 3'd0;
    localparam logic [2:0] ST_RUNNING    = 3'd1;
    localparam logic [2:0] ST_BLOCKED1   = 3'd2;
    localparam logic [2:0] ST_BLOCKED2   = 3'd3;
    localparam logic [2:0] ST_TERMINATED = 3'd4;

    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_DONE1 = 3'd1;
    localparam logic [2:0] K_DONE2 = 3'd2;
    localparam logic [2:0] K_SYS   = 3'd3;
    localparam logic [2:0] K_PC    = 3'd4;
    localparam logic [2:0] K_TERM  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SYS,
        S_UNB_RD,
        S_UNB,
        S_PREEMPT,
        S_POP_RD,
        S_POP,
        S_REPORT,
        S_OUT
    } t_state;

endpackage

/* rtl/rrts_ram.sv */
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/round_robin_task_scheduler_top.sv */
// Round-robin scheduler for NUM_TASKS tasks. One request is taken when
// i_valid is high and o_stall low; one result comes back per request. A
// request runs S_DEC, then S_SYS, S_UNB_RD/S_UNB, S_PREEMPT or none, then
// S_REPORT and S_OUT; a tick or blocking syscall also runs S_POP_RD, S_POP
// for each entry popped from the ready FIFO (stale entries are skipped one
// per pass through the single FIFO read port). After reset the ready FIFO
// is filled one entry a cycle, min(NUM_TASKS-1, QUEUE_DEPTH) entries, during
// which no request is taken. Task tables are registers, the three FIFOs RAMs.
module round_robin_task_scheduler_top #(
    parameter int NUM_TASKS   = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_task_req,
    input  logic        i_device,
    input  logic [15:0] i_pc_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_stop_valid,
    output logic [2:0]  o_stop_task,
    output logic        o_start_valid,
    output logic [2:0]  o_start_task,
    output logic        o_running_valid,
    output logic [2:0]  o_running_task,
    output logic        o_dropped,
    output logic        o_all_done,
    output logic [2:0]  o_task_status,
    output logic [15:0] o_task_pc,
    output logic [15:0] o_dev1_accesses,
    output logic [15:0] o_dev2_accesses
);
    import rrts_pkg::*;

    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = $clog2(NUM_TASKS + 1);
    localparam int NINIT = (NUM_TASKS - 1 < QUEUE_DEPTH) ? NUM_TASKS - 1 : QUEUE_DEPTH;
    localparam logic [CW-1:0] QFULL = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] CINIT = CW'(NINIT);

    t_state r_state, n_state;

    logic [2:0]  r_st [NUM_TASKS];
    logic [15:0] r_pc [NUM_TASKS];
    logic [15:0] r_c1 [NUM_TASKS];
    logic [15:0] r_c2 [NUM_TASKS];
    logic [NUM_TASKS-1:0] r_fr, r_f1, r_f2;
    logic [QW-1:0] r_rh, r_rt, r_h1, r_t1, r_h2, r_t2;
    logic [CW-1:0] r_rc, r_c1n, r_c2n;
    logic          r_cv;
    logic [TW-1:0] r_ct;
    logic [FW-1:0] r_fin;
    logic          r_init;
    logic [CW-1:0] r_icnt;

    logic [2:0]  r_kind, r_treq;
    logic        r_dev;
    logic [15:0] r_pcv;
    logic        r_stop, r_start, r_drop;
    logic [2:0]  r_stopt, r_startt;

    // payload / outputs
    logic        r_ov;
    logic        tv;
    logic [TW-1:0] t;
    assign tv = ({29'd0, r_treq} < 32'(NUM_TASKS));
    assign t  = TW'(r_treq);

    // ram ports
    logic          rq_we, d1_we, d2_we;
    logic [QW-1:0] rq_wa, d1_wa, d2_wa;
    logic [2:0]    rq_wd, d1_wd, d2_wd;
    logic [2:0]    rq_rd, d1_rd, d2_rd;

    rrts_ram #(.WIDTH(3), .DEPTH(QUEUE_DEPTH)) u_rq (
        .i_clk(i_clk), .i_we(rq_we), .i_waddr(rq_wa), .i_wdata(rq_wd),
        .i_raddr(r_rh), .o_rdata(rq_rd));
    rrts_ram #(.WIDTH(3), .DEPTH(QUEUE_DEPTH)) u_d1 (
        .i_clk(i_clk), .i_we(d1_we), .i_waddr(d1_wa), .i_wdata(d1_wd),
        .i_raddr(r_h1), .o_rdata(d1_rd));
    rrts_ram #(.WIDTH(3), .DEPTH(QUEUE_DEPTH)) u_d2 (
        .i_clk(i_clk), .i_we(d2_we), .i_waddr(d2_wa), .i_wdata(d2_wd),
        .i_raddr(r_h2), .o_rdata(d2_rd));
    assign d1_wa = r_t1;
    assign d2_wa = r_t2;

    function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
        qinc = ({{(32-QW){1'b0}}, p} == 32'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // ready-push request, resolved in clocked block
    logic          push_en;
    logic [TW-1:0] push_t;
    logic          pop_ok, pop_valid;
    logic [TW-1:0] pop_t;
    logic [TW-1:0] unb_t;
    logic          unb_ok;

    assign pop_valid = ({29'd0, rq_rd} < 32'(NUM_TASKS));
    assign pop_t     = TW'(rq_rd);
    assign pop_ok    = pop_valid && (r_st[pop_t] == ST_READY);
    assign unb_t     = TW'(r_kind == K_DONE1 ? d1_rd : d2_rd);
    assign unb_ok    = ({29'd0, (r_kind == K_DONE1 ? d1_rd : d2_rd)} < 32'(NUM_TASKS));

    always_comb begin
        push_en = 1'b0;
        push_t  = r_ct;
        unique case (r_state)
            S_PREEMPT: begin
                push_en = r_cv && (r_st[r_ct] == ST_RUNNING);
                push_t  = r_ct;
            end
            S_UNB: begin
                push_en = unb_ok && (r_st[unb_t] != ST_TERMINATED);
                push_t  = unb_t;
            end
            default: ;
        endcase
    end

    logic push_do, push_drop;
    assign push_drop = push_en && !r_fr[push_t] && (r_rc >= QFULL);
    assign push_do   = push_en && !r_fr[push_t] && (r_rc < QFULL);

    assign rq_we = r_init ? 1'b1 : push_do;
    assign rq_wa = r_init ? QW'(r_icnt) : r_rt;
    assign rq_wd = r_init ? 3'(r_icnt + 1'b1) : 3'(push_t);

    logic s_push1, s_push2;
    assign s_push1 = (r_state == S_SYS) && tv && !r_dev && !r_f1[t] && (r_c1n < QFULL);
    assign s_push2 = (r_state == S_SYS) && tv &&  r_dev && !r_f2[t] && (r_c2n < QFULL);
    assign d1_we = s_push1;
    assign d2_we = s_push2;
    assign d1_wd = 3'(t);
    assign d2_wd = 3'(t);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_valid && !o_stall) n_state = S_DEC;
            S_DEC: begin
                n_state = S_REPORT;
                if (r_kind == K_TICK) n_state = S_PREEMPT;
                else if (r_kind == K_DONE1 && r_c1n != '0) n_state = S_UNB_RD;
                else if (r_kind == K_DONE2 && r_c2n != '0) n_state = S_UNB_RD;
                else if (r_kind == K_SYS && tv) n_state = S_SYS;
            end
            S_SYS:     n_state = (r_cv && r_ct == t) ? S_POP_RD : S_REPORT;
            S_UNB_RD:  n_state = S_UNB;
            S_UNB:     n_state = S_REPORT;
            S_PREEMPT: n_state = S_POP_RD;
            S_POP_RD:  n_state = (r_rc == '0) ? S_REPORT : S_POP;
            S_POP:     n_state = pop_ok ? S_REPORT : S_POP_RD;
            S_REPORT:  n_state = S_OUT;
            S_OUT:     if (!i_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    assign o_stall = r_init || (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_st[i] <= (i == 0) ? ST_RUNNING : ST_READY;
                r_pc[i] <= '0;
                r_c1[i] <= '0;
                r_c2[i] <= '0;
                r_fr[i] <= (i >= 1 && i <= NINIT);
            end
            r_f1 <= '0;
            r_f2 <= '0;
            r_rh <= '0;
            r_rt <= QW'(NINIT % QUEUE_DEPTH);
            r_rc <= CINIT;
            r_h1 <= '0; r_t1 <= '0; r_c1n <= '0;
            r_h2 <= '0; r_t2 <= '0; r_c2n <= '0;
            r_cv <= 1'b1;
            r_ct <= '0;
            r_fin <= '0;
            r_init <= (NINIT > 0);
            r_icnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_init) begin
                r_icnt <= r_icnt + 1'b1;
                if (r_icnt + 1'b1 == CINIT) r_init <= 1'b0;
            end
            if (push_do) begin
                r_rt <= qinc(r_rt);
                r_fr[push_t] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_kind <= i_kind; r_treq <= i_task_req;
                    r_dev <= i_device; r_pcv <= i_pc_value;
                    r_stop <= 1'b0; r_start <= 1'b0; r_drop <= 1'b0;
                    r_stopt <= '0; r_startt <= '0;
                end
                S_DEC: begin
                    if (r_kind == K_PC && tv) r_pc[t] <= r_pcv;
                    if (r_kind == K_TERM) begin
                        if ({{(32-FW){1'b0}}, r_fin} < 32'(NUM_TASKS)) r_fin <= r_fin + 1'b1;
                        if (tv) begin
                            r_st[t] <= ST_TERMINATED;
                            r_fr[t] <= 1'b0; r_f1[t] <= 1'b0; r_f2[t] <= 1'b0;
                        end
                    end
                end
                S_SYS: begin
                    r_pc[t] <= r_pcv;
                    r_stop <= 1'b1; r_stopt <= r_treq;
                    if (!r_dev) begin
                        r_st[t] <= ST_BLOCKED1;
                        if (r_c1[t] != 16'hFFFF) r_c1[t] <= r_c1[t] + 1'b1;
                        if (!r_f1[t]) begin
                            if (r_c1n >= QFULL) r_drop <= 1'b1;
                            else begin
                                r_t1 <= qinc(r_t1); r_c1n <= r_c1n + 1'b1;
                                r_f1[t] <= 1'b1;
                            end
                        end
                    end else begin
                        r_st[t] <= ST_BLOCKED2;
                        if (r_c2[t] != 16'hFFFF) r_c2[t] <= r_c2[t] + 1'b1;
                        if (!r_f2[t]) begin
                            if (r_c2n >= QFULL) r_drop <= 1'b1;
                            else begin
                                r_t2 <= qinc(r_t2); r_c2n <= r_c2n + 1'b1;
                                r_f2[t] <= 1'b1;
                            end
                        end
                    end
                    if (r_cv && r_ct == t) r_cv <= 1'b0;
                end
                S_UNB_RD: begin
                    if (r_kind == K_DONE1) begin
                        r_h1 <= qinc(r_h1); r_c1n <= r_c1n - 1'b1;
                    end else begin
                        r_h2 <= qinc(r_h2); r_c2n <= r_c2n - 1'b1;
                    end
                end
                S_UNB: begin
                    if (unb_ok) begin
                        if (r_kind == K_DONE1) r_f1[unb_t] <= 1'b0;
                        else r_f2[unb_t] <= 1'b0;
                        if (r_st[unb_t] != ST_TERMINATED) r_st[unb_t] <= ST_READY;
                    end
                    if (push_drop) r_drop <= 1'b1;
                    if (push_do) r_rc <= r_rc + 1'b1;
                end
                S_PREEMPT: begin
                    if (r_cv && r_st[r_ct] == ST_RUNNING) begin
                        r_stop <= 1'b1; r_stopt <= 3'(r_ct);
                        r_st[r_ct] <= ST_READY;
                    end
                    r_cv <= 1'b0;
                    if (push_drop) r_drop <= 1'b1;
                    if (push_do) r_rc <= r_rc + 1'b1;
                end
                S_POP_RD: if (r_rc != '0) begin
                    r_rh <= qinc(r_rh);
                    r_rc <= r_rc - 1'b1;
                end
                S_POP: begin
                    if (pop_valid) r_fr[pop_t] <= 1'b0;
                    if (pop_ok) begin
                        r_st[pop_t] <= ST_RUNNING;
                        r_cv <= 1'b1; r_ct <= pop_t;
                        r_start <= 1'b1; r_startt <= 3'(pop_t);
                    end
                end
                S_REPORT: begin
                    r_ov <= 1'b1;
                    o_stop_valid    <= r_stop;
                    o_stop_task     <= r_stopt;
                    o_start_valid   <= r_start;
                    o_start_task    <= r_startt;
                    o_running_valid <= r_cv;
                    o_running_task  <= r_cv ? 3'(r_ct) : 3'd0;
                    o_dropped       <= r_drop;
                    o_all_done      <= ({{(32-FW){1'b0}}, r_fin} >= 32'(NUM_TASKS));
                    o_task_status   <= tv ? r_st[t] : 3'd0;
                    o_task_pc       <= tv ? r_pc[t] : 16'd0;
                    o_dev1_accesses <= tv ? r_c1[t] : 16'd0;
                    o_dev2_accesses <= tv ? r_c2[t] : 16'd0;
                end
                S_OUT: if (!i_stall) r_ov <= 1'b0;
                default: ;
            endcase
        end
    end

    assign o_valid = r_ov;
endmodule
